[design/wcf_pkg.sv]
// shared types and constants of the wolff cluster flip unit
// used by every module of the block; depends on nothing else
package wcf_pkg;

  localparam int SIDE_DEFAULT = 16;
  localparam int SITE_IN_W    = 12;
  localparam int CLUSTER_W    = 13;
  localparam int WORD_W       = 32;
  localparam int CFG_IDX_W    = 2;

  // item actions
  typedef enum logic [1:0] {
    ACT_STEP  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd1;

  // neighbour directions in visiting order
  localparam logic [2:0] DIR_XP = 3'd0;
  localparam logic [2:0] DIR_XN = 3'd1;
  localparam logic [2:0] DIR_YP = 3'd2;
  localparam logic [2:0] DIR_YN = 3'd3;
  localparam logic [2:0] DIR_ZP = 3'd4;
  localparam logic [2:0] DIR_ZN = 3'd5;

  // controls from the sequencer to the random unit
  typedef struct packed {
    logic              load_thr;
    logic              load_seed;
    logic              advance;
    logic [WORD_W-1:0] data;
  } rng_ctrl_t;

endpackage

[design/wcf_ram.sv]
// simple dual-port synchronous ram, one write and one registered read per cycle
// depends on wcf_pkg for the default depth
module wcf_ram import wcf_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = SIDE_DEFAULT * SIDE_DEFAULT * SIDE_DEFAULT,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/wcf_rng.sv]
// xorshift32 generator with the bond threshold register and compare
// depends on wcf_pkg for the control struct
module wcf_rng import wcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rng_ctrl_t ctrl_i,
  output logic      hit_o
);

  logic [WORD_W-1:0] state_q, state_d;
  logic [WORD_W-1:0] thr_q, thr_d;
  logic [WORD_W-1:0] x1, x2, draw;

  // next draw from the current state
  always_comb begin
    x1   = state_q ^ (state_q << 13);
    x2   = x1 ^ (x1 >> 17);
    draw = x2 ^ (x2 << 5);
  end

  assign hit_o = draw < thr_q;

  always_comb begin
    state_d = state_q;
    thr_d   = thr_q;
    if (ctrl_i.load_seed) begin
      // a zero seed would lock the generator
      state_d = (ctrl_i.data == '0) ? WORD_W'(1) : ctrl_i.data;
    end else if (ctrl_i.advance) begin
      state_d = draw;
    end
    if (ctrl_i.load_thr) begin
      thr_d = ctrl_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WORD_W'(1);
      thr_q   <= '0;
    end else begin
      state_q <= state_d;
      thr_q   <= thr_d;
    end
  end

endmodule

[design/wolff_cluster_flip_3d_unit.sv]
// wolff cluster flip unit: spin lattice in a 1-bit ram, breadth-first site queue in a second ram
// read items: S_LOOK then S_FINISH to the result register, writes and unused actions S_FINISH only;
// one at a time. cluster step: root flip, z and y split by repeated subtraction, then each popped
// site has its six neighbours scanned, one spin-ram read per neighbour and one queue read per site
// after reset a clearing pass writes every spin bit to 0, input not ready
// configuration port is always ready; all control state resets asynchronously, active low
module wolff_cluster_flip_3d_unit import wcf_pkg::*; #(
  parameter int SIDE = SIDE_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic [SITE_IN_W-1:0] site_i,
  input  logic                 spin_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CLUSTER_W-1:0] flip_count_o,
  output logic                 spin_out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  localparam int NSITES = SIDE * SIDE * SIDE;
  localparam int SITE_W = $clog2(NSITES);
  localparam int CW     = $clog2(SIDE);
  localparam int QW     = 3 * CW;

  localparam logic [SITE_W-1:0] SIDE_L   = SITE_W'(SIDE);
  localparam logic [SITE_W-1:0] S2_L     = SITE_W'(SIDE * SIDE);
  localparam logic [SITE_W-1:0] LAST_L   = SITE_W'(NSITES - 1);
  localparam logic [SITE_W:0]   NSITES_L = (SITE_W + 1)'(NSITES);
  localparam logic [CW-1:0]     CMAX     = CW'(SIDE - 1);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_LOOK   = 9'b000000100,
    S_DIVZ   = 9'b000001000,
    S_DIVY   = 9'b000010000,
    S_POP    = 9'b000100000,
    S_FETCH  = 9'b001000000,
    S_SCAN   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_e;

  // wraparound coordinate steps
  function automatic logic [CW-1:0] step_up(input logic [CW-1:0] c);
    return (c == CMAX) ? '0 : c + CW'(1);
  endfunction

  function automatic logic [CW-1:0] step_dn(input logic [CW-1:0] c);
    return (c == '0) ? CMAX : c - CW'(1);
  endfunction

  // neighbour of a packed {z, y, x} coordinate in one direction
  function automatic logic [QW-1:0] nb_of(input logic [QW-1:0] c, input logic [2:0] dir);
    logic [CW-1:0] x, y, z;
    x = c[CW-1:0];
    y = c[2*CW-1:CW];
    z = c[QW-1:2*CW];
    case (dir)
      DIR_XP:  x = step_up(x);
      DIR_XN:  x = step_dn(x);
      DIR_YP:  y = step_up(y);
      DIR_YN:  y = step_dn(y);
      DIR_ZP:  z = step_up(z);
      DIR_ZN:  z = step_dn(z);
      default: x = x;
    endcase
    return {z, y, x};
  endfunction

  // linear site index from coordinates, constant multiplies only
  function automatic logic [SITE_W-1:0] lin_of(input logic [QW-1:0] c);
    return SITE_W'(c[CW-1:0]) + SITE_W'(c[2*CW-1:CW]) * SIDE_L
         + SITE_W'(c[QW-1:2*CW]) * S2_L;
  endfunction

  // control state
  state_e            state_q, state_d;
  logic [SITE_W-1:0] clr_q, clr_d;
  logic [SITE_W:0]   head_q, head_d;
  logic [SITE_W:0]   tail_q, tail_d;
  logic [2:0]        dir_q, dir_d;
  logic              out_valid_q, out_valid_d;

  // payload registers
  action_e            act_q, act_d;
  logic [SITE_W-1:0]  root_q, root_d;
  logic               old_spin_q, old_spin_d;
  logic               res_spin_q, res_spin_d;
  logic [SITE_W-1:0]  rem_q, rem_d;
  logic [CW-1:0]      cz_q, cz_d;
  logic [CW-1:0]      cy_q, cy_d;
  logic [QW-1:0]      cur_q, cur_d;
  logic [CLUSTER_W-1:0] out_size_q, out_size_d;
  logic               out_spin_q, out_spin_d;

  // memory ports
  logic              spin_we;
  logic [SITE_W-1:0] spin_waddr;
  logic              spin_wdata;
  logic [SITE_W-1:0] spin_raddr;
  logic              spin_rdata;
  logic              q_we;
  logic [SITE_W-1:0] q_waddr;
  logic [QW-1:0]     q_wdata;
  logic [SITE_W-1:0] q_raddr;
  logic [QW-1:0]     q_rdata;

  // bond decision
  rng_ctrl_t rng_ctrl;
  logic      rng_hit;
  logic      nb_match;
  logic      q_room;
  logic      do_join;

  logic              site_ok;
  logic [SITE_W-1:0] site_addr;
  logic [QW-1:0]     fetch_nb;
  logic [QW-1:0]     eval_nb;
  logic [QW-1:0]     next_nb;
  logic              out_load;

  assign site_ok   = 32'(site_i) < 32'(NSITES);
  assign site_addr = SITE_W'(site_i);

  // neighbour of the site just popped, of the one under test and of the next to read
  assign fetch_nb = nb_of(q_rdata, DIR_XP);
  assign eval_nb  = nb_of(cur_q, dir_q);
  assign next_nb  = nb_of(cur_q, dir_q + 3'd1);

  // a draw is spent only on a matching neighbour while the queue has room
  assign nb_match = spin_rdata == old_spin_q;
  assign q_room   = tail_q < NSITES_L;

  always_comb begin
    rng_ctrl.load_thr  = cfg_valid_i && (cfg_idx_i == CFG_BOND);
    rng_ctrl.load_seed = cfg_valid_i && (cfg_idx_i == CFG_SEED);
    rng_ctrl.advance   = (state_q == S_SCAN) && nb_match && q_room;
    rng_ctrl.data      = cfg_data_i;
  end

  assign do_join = rng_ctrl.advance && rng_hit;

  wcf_rng u_rng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rng_ctrl),
    .hit_o  (rng_hit)
  );

  // spin lattice, one bit per site
  wcf_ram #(
    .WIDTH (1),
    .DEPTH (NSITES)
  ) u_spin_ram (
    .clk_i   (clk_i),
    .we_i    (spin_we),
    .waddr_i (spin_waddr),
    .wdata_i (spin_wdata),
    .raddr_i (spin_raddr),
    .rdata_o (spin_rdata)
  );

  // breadth-first queue of packed coordinates
  wcf_ram #(
    .WIDTH (QW),
    .DEPTH (NSITES)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    head_d     = head_q;
    tail_d     = tail_q;
    dir_d      = dir_q;
    act_d      = act_q;
    root_d     = root_q;
    old_spin_d = old_spin_q;
    res_spin_d = res_spin_q;
    rem_d      = rem_q;
    cz_d       = cz_q;
    cy_d       = cy_q;
    cur_d      = cur_q;
    spin_we    = 1'b0;
    spin_waddr = '0;
    spin_wdata = 1'b0;
    spin_raddr = '0;
    q_we       = 1'b0;
    q_waddr    = '0;
    q_wdata    = '0;
    q_raddr    = '0;
    out_load   = 1'b0;

    case (state_q)
      S_CLEAR: begin
        // clearing pass, every spin bit to 0
        spin_we    = 1'b1;
        spin_waddr = clr_q;
        clr_d      = clr_q + SITE_W'(1);
        if (clr_q == LAST_L) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          act_d      = action_e'(action_i);
          root_d     = site_addr;
          head_d     = '0;
          tail_d     = '0;
          res_spin_d = 1'b0;
          state_d    = S_FINISH;
          if (site_ok) begin
            case (action_i)
              ACT_STEP, ACT_READ: begin
                spin_raddr = site_addr;
                state_d    = S_LOOK;
              end
              ACT_WRITE: begin
                spin_we    = 1'b1;
                spin_waddr = site_addr;
                spin_wdata = spin_in_i;
              end
              default: state_d = S_FINISH;
            endcase
          end
        end
      end
      S_LOOK: begin
        if (act_q == ACT_READ) begin
          res_spin_d = spin_rdata;
          state_d    = S_FINISH;
        end else begin
          // flip the root, then split its index into coordinates
          old_spin_d = spin_rdata;
          res_spin_d = ~spin_rdata;
          spin_we    = 1'b1;
          spin_waddr = root_q;
          spin_wdata = ~spin_rdata;
          rem_d      = root_q;
          cz_d       = '0;
          cy_d       = '0;
          state_d    = S_DIVZ;
        end
      end
      S_DIVZ: begin
        if (rem_q >= S2_L) begin
          rem_d = rem_q - S2_L;
          cz_d  = cz_q + CW'(1);
        end else begin
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (rem_q >= SIDE_L) begin
          rem_d = rem_q - SIDE_L;
          cy_d  = cy_q + CW'(1);
        end else begin
          // root enters the queue
          q_we    = 1'b1;
          q_waddr = '0;
          q_wdata = {cz_q, cy_q, CW'(rem_q)};
          tail_d  = (SITE_W + 1)'(1);
          state_d = S_POP;
        end
      end
      S_POP: begin
        if (head_q == tail_q) begin
          state_d = S_FINISH;
        end else begin
          q_raddr = head_q[SITE_W-1:0];
          head_d  = head_q + (SITE_W + 1)'(1);
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cur_d      = q_rdata;
        spin_raddr = lin_of(fetch_nb);
        dir_d      = DIR_XP;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        // test the neighbour read last cycle, read the next one
        if (do_join) begin
          spin_we    = 1'b1;
          spin_waddr = lin_of(eval_nb);
          spin_wdata = ~old_spin_q;
          q_we       = 1'b1;
          q_waddr    = tail_q[SITE_W-1:0];
          q_wdata    = eval_nb;
          tail_d     = tail_q + (SITE_W + 1)'(1);
        end
        if (dir_q == DIR_ZN) begin
          state_d = S_POP;
        end else begin
          spin_raddr = lin_of(next_nb);
          dir_d      = dir_q + 3'd1;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_size_d  = out_size_q;
    out_spin_d  = out_spin_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_size_d  = CLUSTER_W'(tail_q);
      out_spin_d  = res_spin_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      dir_q       <= DIR_XP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    root_q     <= root_d;
    old_spin_q <= old_spin_d;
    res_spin_q <= res_spin_d;
    rem_q      <= rem_d;
    cz_q       <= cz_d;
    cy_q       <= cy_d;
    cur_q      <= cur_d;
    out_size_q <= out_size_d;
    out_spin_q <= out_spin_d;
  end

  assign in_ready_o     = state_q == S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign flip_count_o   = out_size_q;
  assign spin_out_o     = out_spin_q;
  assign cfg_ready_o    = 1'b1;

  // the flip of one neighbour never lands on the address read in the same cycle
  a_scan_no_collide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && spin_we && dir_q != DIR_ZN) |-> (spin_waddr != spin_raddr))
    else $error("spin ram write and read collide during scan");

  // the queue never holds more sites than the lattice
  a_tail_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= NSITES_L)
    else $error("queue tail beyond lattice size");

  // the head never passes the tail
  a_head_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP || state_q == S_FETCH || state_q == S_SCAN) |-> (head_q <= tail_q))
    else $error("queue head passed tail");

endmodule
